[rtl/barh_pkg.sv]
// Types and constants shared by the bootloader ACK/NACK handshake block.
`timescale 1ns / 1ps
package barh_pkg;

   localparam int CFG_MS_W    = 16;
   localparam int BYTE_W      = 8;
   localparam int PHASE_W     = 4;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [BYTE_W-1:0]   CHECK_MASK       = 8'hFF;
   localparam logic [BYTE_W-1:0]   NACK_COUNT_MAX   = 8'hFF;
   localparam logic [CFG_MS_W-1:0] OVERALL_LIMIT_RST = 16'd1000;
   localparam logic [CFG_MS_W-1:0] GAP_RST           = 16'd200;
   localparam logic [BYTE_W-1:0]   NACK_LIMIT_RST    = 8'd5;
   localparam logic [BYTE_W-1:0]   ACK_CODE_RST      = 8'd121;
   localparam logic [BYTE_W-1:0]   NACK_CODE_RST     = 8'd31;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE      = 4'd0,
      PH_GAP_RESET = 4'd1,
      PH_GAP_WAIT  = 4'd2,
      PH_SEND      = 4'd3,
      PH_WAIT      = 4'd4,
      PH_ACK       = 4'd5,
      PH_NACK      = 4'd6,
      PH_TIMEOUT   = 4'd7,
      PH_READY     = 4'd8,
      PH_ERROR     = 4'd9
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY       = 3'd0,
      ST_DONE       = 3'd1,
      ST_TIMEOUT    = 3'd2,
      ST_NACK_LIMIT = 3'd3,
      ST_ERROR      = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OVERALL_LIMIT = 3'd0,
      CSR_GAP           = 3'd1,
      CSR_NACK_LIMIT    = 3'd2,
      CSR_APPEND_CHECK  = 3'd3,
      CSR_ACK_CODE      = 3'd4,
      CSR_NACK_CODE     = 3'd5
   } csr_index_type;

endpackage

[rtl/bootloader_ack_retry_handshake.sv]
// Top level: master-side ACK/NACK retry handshake of a UART bootloader exchange.
// rsp_valid rises once an accepted request passes the input, then the result register.
// Throughput: one request per cycle unless rsp_ready stalls; one compare-and-count pass.
// The input register takes a new request while a finished result waits on rsp_ready.
// Reset: synchronous, clears phase, timers, NACK count, valids; config to defaults.
`timescale 1ns / 1ps
module bootloader_ack_retry_handshake #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic                                req_ms_tick,
   input  logic                                req_rx_valid,
   input  logic [barh_pkg::BYTE_W-1:0]         req_rx_byte,
   input  logic [barh_pkg::BYTE_W-1:0]         req_first_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_transmit_now,
   output logic                                rsp_check_valid,
   output logic [barh_pkg::BYTE_W-1:0]         rsp_check_byte,
   output logic [barh_pkg::STATUS_W-1:0]       rsp_status,
   output logic [barh_pkg::PHASE_W-1:0]        rsp_phase_now,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [barh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [barh_pkg::CSR_DATA_W-1:0]     csr_data
);
   import barh_pkg::*;

   localparam int CMP_W = (TIMER_WIDTH > CFG_MS_W) ? TIMER_WIDTH : CFG_MS_W;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   // configuration
   logic [CFG_MS_W-1:0] overall_limit_ff;
   logic [CFG_MS_W-1:0] gap_ms_ff;
   logic [BYTE_W-1:0]   nack_limit_ff;
   logic                append_check_ff;
   logic [BYTE_W-1:0]   ack_code_ff;
   logic [BYTE_W-1:0]   nack_code_ff;

   // input register
   logic              in_valid_ff;
   logic              action_ff;
   logic              tick_ff;
   logic              rx_valid_ff;
   logic [BYTE_W-1:0] rx_byte_ff;
   logic [BYTE_W-1:0] first_byte_ff;

   // handshake state
   phase_type             phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] gap_elapsed_ff, gap_elapsed_in;
   logic [TIMER_WIDTH-1:0] overall_elapsed_ff, overall_elapsed_in;
   logic [BYTE_W-1:0]      nack_count_ff, nack_count_in;
   logic [BYTE_W-1:0]      held_command_ff, held_command_in;

   // result register
   logic                 out_valid_ff;
   logic                 tx_ff, tx_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [BYTE_W-1:0]    chk_byte_ff, chk_byte_in;
   status_type           status_ff, status_in;
   logic [PHASE_W-1:0]   phase_out_ff;

   logic                   advance;
   logic                   count_tick;
   logic [TIMER_WIDTH-1:0] gap_inc;
   logic [TIMER_WIDTH-1:0] overall_inc;
   logic [BYTE_W-1:0]      nack_inc;
   logic                   is_ack;
   logic                   is_nack;
   logic                   gap_done;
   logic                   overall_done;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         overall_limit_ff <= OVERALL_LIMIT_RST;
         gap_ms_ff        <= GAP_RST;
         nack_limit_ff    <= NACK_LIMIT_RST;
         append_check_ff  <= 1'b0;
         ack_code_ff      <= ACK_CODE_RST;
         nack_code_ff     <= NACK_CODE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_OVERALL_LIMIT: overall_limit_ff <= csr_data;
            CSR_GAP:           gap_ms_ff        <= csr_data;
            CSR_NACK_LIMIT:    nack_limit_ff    <= csr_data[BYTE_W-1:0];
            CSR_APPEND_CHECK:  append_check_ff  <= csr_data[0];
            CSR_ACK_CODE:      ack_code_ff      <= csr_data[BYTE_W-1:0];
            CSR_NACK_CODE:     nack_code_ff     <= csr_data[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         action_ff     <= req_action;
         tick_ff       <= req_ms_tick;
         rx_valid_ff   <= req_rx_valid;
         rx_byte_ff    <= req_rx_byte;
         first_byte_ff <= req_first_byte;
      end
   end

   assign count_tick  = tick_ff && (phase_ff != PH_IDLE);
   assign gap_inc     = (count_tick && gap_elapsed_ff != TIMER_MAX)
                        ? gap_elapsed_ff + 1'b1 : gap_elapsed_ff;
   assign overall_inc = (count_tick && overall_elapsed_ff != TIMER_MAX)
                        ? overall_elapsed_ff + 1'b1 : overall_elapsed_ff;
   assign nack_inc    = (nack_count_ff != NACK_COUNT_MAX) ? nack_count_ff + 1'b1
                                                          : nack_count_ff;
   assign gap_done     = CMP_W'(gap_inc) > CMP_W'(gap_ms_ff);
   assign overall_done = CMP_W'(overall_inc) > CMP_W'(overall_limit_ff);
   assign is_ack       = rx_valid_ff && (rx_byte_ff == ack_code_ff);
   assign is_nack      = rx_valid_ff && (rx_byte_ff == nack_code_ff);

   // next state
   always_comb begin
      phase_in           = phase_ff;
      gap_elapsed_in     = gap_inc;
      overall_elapsed_in = overall_inc;
      nack_count_in      = nack_count_ff;
      held_command_in    = held_command_ff;
      if (action_ff) begin
         held_command_in    = first_byte_ff;
         nack_count_in      = '0;
         overall_elapsed_in = '0;
         gap_elapsed_in     = '0;
         phase_in           = PH_GAP_RESET;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               nack_count_in = '0;
            end
            PH_GAP_RESET: begin
               gap_elapsed_in = '0;
               phase_in       = PH_GAP_WAIT;
            end
            PH_GAP_WAIT: begin
               if (gap_done) begin
                  phase_in = PH_SEND;
               end
            end
            PH_SEND: begin
               phase_in = PH_WAIT;
            end
            PH_WAIT: begin
               if (overall_done) begin
                  phase_in = PH_TIMEOUT;
               end else if (is_ack) begin
                  phase_in = PH_ACK;
               end else if (is_nack) begin
                  phase_in = PH_NACK;
               end
            end
            PH_ACK: begin
               phase_in = PH_READY;
            end
            PH_NACK: begin
               nack_count_in = nack_inc;
               phase_in      = (nack_inc > nack_limit_ff) ? PH_IDLE : PH_GAP_RESET;
            end
            PH_TIMEOUT, PH_READY, PH_ERROR: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      tx_in        = 1'b0;
      chk_valid_in = 1'b0;
      chk_byte_in  = '0;
      status_in    = ST_BUSY;
      if (!action_ff) begin
         case (phase_ff)
            PH_SEND: begin
               tx_in = 1'b1;
               if (append_check_ff) begin
                  chk_valid_in = 1'b1;
                  chk_byte_in  = CHECK_MASK ^ held_command_ff;
               end
            end
            PH_NACK: begin
               if (nack_inc > nack_limit_ff) begin
                  status_in = ST_NACK_LIMIT;
               end
            end
            PH_TIMEOUT: status_in = ST_TIMEOUT;
            PH_READY:   status_in = ST_DONE;
            PH_ERROR:   status_in = ST_ERROR;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         gap_elapsed_ff     <= '0;
         overall_elapsed_ff <= '0;
         nack_count_ff      <= '0;
         held_command_ff    <= '0;
      end else if (advance) begin
         phase_ff           <= phase_in;
         gap_elapsed_ff     <= gap_elapsed_in;
         overall_elapsed_ff <= overall_elapsed_in;
         nack_count_ff      <= nack_count_in;
         held_command_ff    <= held_command_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tx_ff        <= tx_in;
         chk_valid_ff <= chk_valid_in;
         chk_byte_ff  <= chk_byte_in;
         status_ff    <= status_in;
         phase_out_ff <= phase_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_transmit_now = tx_ff;
   assign rsp_check_valid  = chk_valid_ff;
   assign rsp_check_byte   = chk_byte_ff;
   assign rsp_status       = status_ff;
   assign rsp_phase_now    = phase_out_ff;

endmodule

[rtl/barh_checker.sv]
// Port-level checker for the bootloader handshake block, bound to the top level.
`timescale 1ns / 1ps
module barh_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_transmit_now,
   input logic                             rsp_check_valid,
   input logic [barh_pkg::BYTE_W-1:0]      rsp_check_byte,
   input logic [barh_pkg::STATUS_W-1:0]    rsp_status,
   input logic [barh_pkg::PHASE_W-1:0]     rsp_phase_now
);
   import barh_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_check_valid |-> rsp_transmit_now)
      else $error("check byte without transmit pulse");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_check_valid |-> rsp_check_byte == '0)
      else $error("check byte set while not valid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_BUSY |-> rsp_phase_now == PH_IDLE)
      else $error("final status outside idle phase");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_transmit_now |-> rsp_phase_now == PH_WAIT)
      else $error("transmit pulse not followed by reply wait");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase_now)
         && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind bootloader_ack_retry_handshake barh_checker u_barh_checker (.*);
